### src/z80_subset_execute_core_macros.svh
// Assertion macros for the Z80 subset execute core checker.
`ifndef Z80_SUBSET_EXECUTE_CORE_MACROS_SVH
`define Z80_SUBSET_EXECUTE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define Z80SE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define Z80SE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/z80se_pkg.sv
// Shared types and constants for the Z80 subset execute core.
package z80se_pkg;

	localparam int IN_W  = 24;
	localparam int OUT_W = 88;

	localparam int OUT_FLAGS_LSB  = 8;
	localparam int OUT_PC_LSB     = 64;
	localparam int OUT_STATUS_LSB = 80;

	typedef enum logic [1:0] {
		ST_EXEC  = 2'd0,
		ST_HALT  = 2'd1,
		ST_UNSUP = 2'd2
	} status_t;

	// x field of the opcode
	localparam logic [1:0] X_MISC = 2'd0;
	localparam logic [1:0] X_ALU  = 2'd2;
	localparam logic [1:0] X_JP   = 2'd3;

	// z field of the opcode
	localparam logic [2:0] Z_NOP  = 3'd0;
	localparam logic [2:0] Z_JPCC = 3'd2;
	localparam logic [2:0] Z_JP   = 3'd3;
	localparam logic [2:0] Z_INC  = 3'd4;
	localparam logic [2:0] Z_DEC  = 3'd5;
	localparam logic [2:0] Z_LDI  = 3'd6;

	// register codes
	localparam logic [2:0] REG_B  = 3'd0;
	localparam logic [2:0] REG_C  = 3'd1;
	localparam logic [2:0] REG_D  = 3'd2;
	localparam logic [2:0] REG_E  = 3'd3;
	localparam logic [2:0] REG_H  = 3'd4;
	localparam logic [2:0] REG_L  = 3'd5;
	localparam logic [2:0] REG_HL = 3'd6;
	localparam logic [2:0] REG_A  = 3'd7;

	// ALU operations
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	// jump conditions
	localparam logic [2:0] CC_NZ = 3'd0;
	localparam logic [2:0] CC_Z  = 3'd1;
	localparam logic [2:0] CC_NC = 3'd2;
	localparam logic [2:0] CC_C  = 3'd3;
	localparam logic [2:0] CC_PO = 3'd4;
	localparam logic [2:0] CC_PE = 3'd5;
	localparam logic [2:0] CC_P  = 3'd6;
	localparam logic [2:0] CC_M  = 3'd7;

	// flag bit positions
	localparam int FB_S  = 7;
	localparam int FB_Z  = 6;
	localparam int FB_Y  = 5;
	localparam int FB_H  = 4;
	localparam int FB_X  = 3;
	localparam int FB_PV = 2;
	localparam int FB_N  = 1;
	localparam int FB_C  = 0;

endpackage

### src/z80_subset_execute_core.sv
// Z80 subset execute core: runs one fetched instruction per transaction.
// Each input transaction carries one opcode and its two following bytes; the core executes
// it against its own A, F, B-L, PC and halted flag and returns every register, the next
// PC and a status (0 executed, 1 halted, 2 unsupported). The instruction sits in an input
// register while decode, the 8-bit ALU and flag logic run, and the architectural state
// and the output register load together on the edge that takes it out of that register;
// one instruction retires every cycle while the output is not stalled, and the throughput
// is set by the update loop of the register file through the ALU. After a NOP or an
// unsupported opcode the core stays halted until reset and echoes its state with status 1.
module z80_subset_execute_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// opcode, imm_low, imm_high
	input  logic [z80se_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// acc_out, flags_out, b_out, c_out, d_out, e_out, h_out, l_out, pc_out, status, zero pad
	output logic [z80se_pkg::OUT_W-1:0] m_axis_tdata
);
	import z80se_pkg::*;

	logic [IN_W-1:0]  in_s1;
	logic             in_vld_s1;
	logic [OUT_W-1:0] out_s2;
	logic             out_vld_s2;

	logic [7:0]  a_q, f_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] pc_q;
	logic        halted_q;

	logic        fire;
	logic [7:0]  op, lo, hi;
	logic [1:0]  fx;
	logic [2:0]  fy, fz;
	logic [7:0]  src_y, src_z;

	logic        sub, cin, ci;
	logic [7:0]  bb, ares;
	logic [8:0]  sum9;
	logic [4:0]  half5;
	logic [7:0]  arith_f;
	logic [7:0]  lres;
	logic [7:0]  inc_r, dec_r;
	logic        cond;

	logic        wr_en;
	logic [2:0]  wr_code;
	logic [7:0]  wr_val;
	logic [7:0]  a_n, f_n, b_n, c_n, d_n, e_n, h_n, l_n;
	logic [15:0] pc_n;
	logic        halted_n;
	status_t     status_n;

	assign fire          = in_vld_s1 && (!out_vld_s2 || m_axis_tready);
	assign s_axis_tready = !in_vld_s1 || fire;
	assign m_axis_tvalid = out_vld_s2;
	assign m_axis_tdata  = out_s2;

	assign op = in_s1[7:0];
	assign lo = in_s1[15:8];
	assign hi = in_s1[23:16];
	assign fx = op[7:6];
	assign fy = op[5:3];
	assign fz = op[2:0];

	always_comb begin
		case (fy)
			REG_B:   src_y = b_q;
			REG_C:   src_y = c_q;
			REG_D:   src_y = d_q;
			REG_E:   src_y = e_q;
			REG_H:   src_y = h_q;
			REG_L:   src_y = l_q;
			default: src_y = a_q;
		endcase
	end

	always_comb begin
		case (fz)
			REG_B:   src_z = b_q;
			REG_C:   src_z = c_q;
			REG_D:   src_z = d_q;
			REG_E:   src_z = e_q;
			REG_H:   src_z = h_q;
			REG_L:   src_z = l_q;
			default: src_z = a_q;
		endcase
	end

	// add/subtract with carry, Z80 flags
	assign sub   = (fy == ALU_SUB) || (fy == ALU_SBC) || (fy == ALU_CP);
	assign cin   = ((fy == ALU_ADC) || (fy == ALU_SBC)) && f_q[FB_C];
	assign bb    = sub ? ~src_z : src_z;
	assign ci    = sub ? ~cin : cin;
	assign sum9  = {1'b0, a_q} + {1'b0, bb} + {8'd0, ci};
	assign half5 = {1'b0, a_q[3:0]} + {1'b0, bb[3:0]} + {4'd0, ci};
	assign ares  = sum9[7:0];
	assign arith_f = {ares[7], ares == 8'd0, 1'b0, half5[4] ^ sub, 1'b0,
		((a_q ^ ares) & (bb ^ ares)) >> 7 != 8'd0, sub, sum9[8] ^ sub};

	always_comb begin
		case (fy)
			ALU_AND: lres = a_q & src_z;
			ALU_XOR: lres = a_q ^ src_z;
			default: lres = a_q | src_z;
		endcase
	end

	assign inc_r = src_y + 8'd1;
	assign dec_r = src_y - 8'd1;

	always_comb begin
		case (fy)
			CC_NZ:   cond = !f_q[FB_Z];
			CC_Z:    cond = f_q[FB_Z];
			CC_NC:   cond = !f_q[FB_C];
			CC_C:    cond = f_q[FB_C];
			CC_PO:   cond = !f_q[FB_PV];
			CC_PE:   cond = f_q[FB_PV];
			CC_P:    cond = !f_q[FB_S];
			default: cond = f_q[FB_S];
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_code  = fy;
		wr_val   = 8'd0;
		f_n      = f_q;
		pc_n     = pc_q;
		halted_n = halted_q;
		status_n = ST_EXEC;
		if (halted_q) begin
			status_n = ST_HALT;
		end else begin
			status_n = ST_UNSUP;
			halted_n = 1'b1;
			case (fx)
				X_MISC: begin
					if (fz == Z_NOP && fy == REG_B) begin
						status_n = ST_HALT;
					end else if (fy != REG_HL && fz == Z_INC) begin
						wr_en    = 1'b1;
						wr_val   = inc_r;
						f_n      = {inc_r[7], inc_r == 8'd0, 1'b0, src_y[3:0] == 4'hF, 1'b0,
							src_y == 8'h7F, 1'b0, f_q[FB_C]};
						pc_n     = pc_q + 16'd1;
						status_n = ST_EXEC;
						halted_n = 1'b0;
					end else if (fy != REG_HL && fz == Z_DEC) begin
						wr_en    = 1'b1;
						wr_val   = dec_r;
						f_n      = {dec_r[7], dec_r == 8'd0, 1'b0, src_y[3:0] == 4'h0, 1'b0,
							src_y == 8'h80, 1'b1, f_q[FB_C]};
						pc_n     = pc_q + 16'd1;
						status_n = ST_EXEC;
						halted_n = 1'b0;
					end else if (fy != REG_HL && fz == Z_LDI) begin
						wr_en    = 1'b1;
						wr_val   = lo;
						pc_n     = pc_q + 16'd2;
						status_n = ST_EXEC;
						halted_n = 1'b0;
					end
				end
				X_ALU: begin
					if (fz != REG_HL) begin
						wr_code  = REG_A;
						pc_n     = pc_q + 16'd1;
						status_n = ST_EXEC;
						halted_n = 1'b0;
						if (fy == ALU_AND || fy == ALU_XOR || fy == ALU_OR) begin
							wr_en  = 1'b1;
							wr_val = lres;
							f_n    = {lres[7], lres == 8'd0, 1'b0, fy == ALU_AND, 1'b0,
								~^lres, 1'b0, 1'b0};
						end else begin
							wr_en  = (fy != ALU_CP);
							wr_val = ares;
							f_n    = arith_f;
						end
					end
				end
				X_JP: begin
					if (fz == Z_JPCC) begin
						pc_n     = cond ? {hi, lo} : pc_q + 16'd3;
						status_n = ST_EXEC;
						halted_n = 1'b0;
					end else if (fz == Z_JP && fy == REG_B) begin
						pc_n     = {hi, lo};
						status_n = ST_EXEC;
						halted_n = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign a_n = (wr_en && wr_code == REG_A) ? wr_val : a_q;
	assign b_n = (wr_en && wr_code == REG_B) ? wr_val : b_q;
	assign c_n = (wr_en && wr_code == REG_C) ? wr_val : c_q;
	assign d_n = (wr_en && wr_code == REG_D) ? wr_val : d_q;
	assign e_n = (wr_en && wr_code == REG_E) ? wr_val : e_q;
	assign h_n = (wr_en && wr_code == REG_H) ? wr_val : h_q;
	assign l_n = (wr_en && wr_code == REG_L) ? wr_val : l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1  <= 1'b0;
			out_vld_s2 <= 1'b0;
			a_q        <= 8'd0;
			f_q        <= 8'd0;
			b_q        <= 8'd0;
			c_q        <= 8'd0;
			d_q        <= 8'd0;
			e_q        <= 8'd0;
			h_q        <= 8'd0;
			l_q        <= 8'd0;
			pc_q       <= 16'd0;
			halted_q   <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_vld_s1 <= 1'b1;
			end else if (fire) begin
				in_vld_s1 <= 1'b0;
			end
			if (fire) begin
				out_vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_s2 <= 1'b0;
			end
			if (fire) begin
				a_q      <= a_n;
				f_q      <= f_n;
				b_q      <= b_n;
				c_q      <= c_n;
				d_q      <= d_n;
				e_q      <= e_n;
				h_q      <= h_n;
				l_q      <= l_n;
				pc_q     <= pc_n;
				halted_q <= halted_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_s1 <= s_axis_tdata;
		end
		if (fire) begin
			out_s2 <= {6'd0, status_n, pc_n, l_n, h_n, e_n, d_n, c_n, b_n, f_n, a_n};
		end
	end

endmodule

### src/z80se_checker.sv
// Port-level assertions for the Z80 subset execute core, with bind.
`include "z80_subset_execute_core_macros.svh"

module z80se_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [z80se_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [z80se_pkg::OUT_W-1:0] m_axis_tdata
);
	import z80se_pkg::*;

	logic        m_xfer;
	logic [1:0]  m_status;
	logic [15:0] m_pc;
	logic        stop_seen_q;
	logic [15:0] last_pc_q;

	assign m_xfer   = m_axis_tvalid && m_axis_tready;
	assign m_status = m_axis_tdata[OUT_STATUS_LSB +: 2];
	assign m_pc     = m_axis_tdata[OUT_PC_LSB +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_seen_q <= 1'b0;
			last_pc_q   <= 16'd0;
		end else if (m_xfer) begin
			stop_seen_q <= stop_seen_q || (m_status != ST_EXEC);
			last_pc_q   <= m_pc;
		end
	end

	// once stopped, every later transaction reports halted
	`Z80SE_ASSERT_SAME(a_halt_sticky, m_xfer && stop_seen_q, m_status == ST_HALT, "halt not sticky")

	// a halted or unsupported result leaves the PC where it was
	`Z80SE_ASSERT_SAME(a_pc_hold, m_xfer && m_status != ST_EXEC, m_pc == last_pc_q, "pc moved on stop")

	// undocumented flag bits stay clear
	`Z80SE_ASSERT_SAME(a_flag_xy, m_axis_tvalid, m_axis_tdata[OUT_FLAGS_LSB + FB_Y] == 1'b0 && m_axis_tdata[OUT_FLAGS_LSB + FB_X] == 1'b0, "flag bit 5 or 3 set")

	// stalled result holds
	`Z80SE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind z80_subset_execute_core z80se_checker u_z80se_checker (.*);

### tb/tb.sv
// Self-checking testbench for the Z80 subset execute core: directed, random and halt tests.
module tb;
	import z80se_pkg::*;

	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_JP_NN   = 8'hC3;
	localparam int         STALL_MAX  = 5000;
	localparam int         N_RANDOM   = 375;
	localparam int         N_HALTED   = 6;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] pc;
		logic [7:0]  l, h, e, d, c, b, flags, acc;
	} core_view_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;   // opcode, imm_low, imm_high
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // acc, flags, b, c, d, e, h, l, pc, status, pad

	// architectural state as predicted
	logic [7:0]  a_reg = '0;
	logic [7:0]  f_reg = '0;
	logic [7:0]  gpr [0:5] = '{default: '0};
	logic [15:0] pc_reg = '0;
	bit          is_halted = 1'b0;

	core_view_t predicted_views [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int n_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int n_jumps = 0;

	z80_subset_execute_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] read_reg(input logic [2:0] code);
		return (code == REG_A) ? a_reg : gpr[code];
	endfunction

	function automatic void write_reg(input logic [2:0] code, input logic [7:0] v);
		if (code == REG_A) a_reg = v;
		else gpr[code] = v;
	endfunction

	function automatic logic [7:0] add_sub(input logic [7:0] x, y, input logic cin, sub,
			output logic [7:0] fl);
		logic [7:0] yy;
		logic       ci;
		logic [8:0] sum;
		logic [4:0] nib;
		logic [7:0] r;
		yy = sub ? ~y : y;
		ci = sub ? ~cin : cin;
		sum = {1'b0, x} + {1'b0, yy} + 9'(ci);
		nib = {1'b0, x[3:0]} + {1'b0, yy[3:0]} + 5'(ci);
		r = sum[7:0];
		fl = '0;
		fl[FB_S] = r[7];
		fl[FB_Z] = (r == 8'd0);
		fl[FB_H] = nib[4] ^ sub;
		fl[FB_PV] = (x[7] ^ r[7]) & (yy[7] ^ r[7]);
		fl[FB_N] = sub;
		fl[FB_C] = sum[8] ^ sub;
		return r;
	endfunction

	function automatic logic [7:0] logic_flags(input logic [7:0] r, input logic hset);
		logic [7:0] fl;
		fl = '0;
		fl[FB_S] = r[7];
		fl[FB_Z] = (r == 8'd0);
		fl[FB_H] = hset;
		fl[FB_PV] = ~^r;
		return fl;
	endfunction

	function automatic logic cond_met(input logic [2:0] cc);
		case (cc)
			CC_NZ: return !f_reg[FB_Z];
			CC_Z:  return f_reg[FB_Z];
			CC_NC: return !f_reg[FB_C];
			CC_C:  return f_reg[FB_C];
			CC_PO: return !f_reg[FB_PV];
			CC_PE: return f_reg[FB_PV];
			CC_P:  return !f_reg[FB_S];
			default: return f_reg[FB_S];
		endcase
	endfunction

	// Runs one instruction on the predicted state and returns the core's expected view.
	function automatic core_view_t execute_instr(input logic [7:0] op, lo, hi);
		logic [1:0] x;
		logic [2:0] y, z;
		logic [7:0] v, r, fl;
		logic       done;
		status_t    st;
		core_view_t view;
		x = op[7:6];
		y = op[5:3];
		z = op[2:0];
		done = 1'b0;
		st = ST_EXEC;
		if (is_halted) begin
			st = ST_HALT;
			done = 1'b1;
		end else if (op == OP_NOP) begin
			is_halted = 1'b1;
			st = ST_HALT;
			done = 1'b1;
		end else if (x == X_MISC && y != REG_HL) begin
			v = read_reg(y);
			if (z == Z_INC) begin
				r = v + 8'd1;
				fl = logic_flags(r, v[3:0] == 4'hF);
				fl[FB_PV] = (v == 8'h7F);
				fl[FB_C] = f_reg[FB_C];
				write_reg(y, r);
				f_reg = fl;
				pc_reg = pc_reg + 16'd1;
				done = 1'b1;
			end else if (z == Z_DEC) begin
				r = v - 8'd1;
				fl = logic_flags(r, v[3:0] == 4'h0);
				fl[FB_PV] = (v == 8'h80);
				fl[FB_N] = 1'b1;
				fl[FB_C] = f_reg[FB_C];
				write_reg(y, r);
				f_reg = fl;
				pc_reg = pc_reg + 16'd1;
				done = 1'b1;
			end else if (z == Z_LDI) begin
				write_reg(y, lo);
				pc_reg = pc_reg + 16'd2;
				done = 1'b1;
			end
		end else if (x == X_ALU && z != REG_HL) begin
			v = read_reg(z);
			case (y)
				ALU_ADD: a_reg = add_sub(a_reg, v, 1'b0, 1'b0, f_reg);
				ALU_ADC: a_reg = add_sub(a_reg, v, f_reg[FB_C], 1'b0, f_reg);
				ALU_SUB: a_reg = add_sub(a_reg, v, 1'b0, 1'b1, f_reg);
				ALU_SBC: a_reg = add_sub(a_reg, v, f_reg[FB_C], 1'b1, f_reg);
				ALU_AND: begin
					a_reg = a_reg & v;
					f_reg = logic_flags(a_reg, 1'b1);
				end
				ALU_XOR: begin
					a_reg = a_reg ^ v;
					f_reg = logic_flags(a_reg, 1'b0);
				end
				ALU_OR: begin
					a_reg = a_reg | v;
					f_reg = logic_flags(a_reg, 1'b0);
				end
				default: void'(add_sub(a_reg, v, 1'b0, 1'b1, f_reg));
			endcase
			pc_reg = pc_reg + 16'd1;
			done = 1'b1;
		end else if (x == X_JP && z == Z_JPCC) begin
			pc_reg = cond_met(y) ? {hi, lo} : pc_reg + 16'd3;
			done = 1'b1;
		end else if (op == OP_JP_NN) begin
			pc_reg = {hi, lo};
			done = 1'b1;
		end
		if (!done) begin
			is_halted = 1'b1;
			st = ST_UNSUP;
		end
		view.st = st;
		view.pc = pc_reg;
		view.acc = a_reg;
		view.flags = f_reg;
		view.b = gpr[REG_B];
		view.c = gpr[REG_C];
		view.d = gpr[REG_D];
		view.e = gpr[REG_E];
		view.h = gpr[REG_H];
		view.l = gpr[REG_L];
		return view;
	endfunction

	function automatic void check_field(input string fname, input logic [15:0] want_v, got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s of result %0d: expected %h, got %h",
					fname, results_seen, want_v, got_v);
		end
	endfunction

	// prediction on each accepted instruction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predicted_views.push_back(execute_instr(s_axis_tdata[7:0], s_axis_tdata[15:8],
				s_axis_tdata[23:16]));
			n_accepted++;
			if (s_axis_tdata[7:6] == X_JP) n_jumps++;
		end
	end

	// result checking
	always @(posedge clk) begin
		core_view_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = core_view_t'(m_axis_tdata[OUT_STATUS_LSB+1:0]);
			if (predicted_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no instruction pending: %h",
						results_seen, got);
			end else begin
				want = predicted_views.pop_front();
				check_field("acc", 16'(want.acc), 16'(got.acc));
				check_field("flags", 16'(want.flags), 16'(got.flags));
				check_field("B", 16'(want.b), 16'(got.b));
				check_field("C", 16'(want.c), 16'(got.c));
				check_field("D", 16'(want.d), 16'(got.d));
				check_field("E", 16'(want.e), 16'(got.e));
				check_field("H", 16'(want.h), 16'(got.h));
				check_field("L", 16'(want.l), 16'(got.l));
				check_field("PC", want.pc, got.pc);
				check_field("status", 16'(want.st), 16'(got.st));
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_MAX) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("z80_subset_execute_core verification failed");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
	end

	task automatic send_instr(input logic [7:0] op, lo, hi);
		while ($urandom_range(1, 100) <= send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hi, lo, op};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (predicted_views.size() != 0);
	endtask

	function automatic logic [2:0] random_reg();
		logic [2:0] r;
		r = 3'($urandom_range(0, 6));
		if (r == REG_HL) r = REG_A;
		return r;
	endfunction

	function automatic logic [7:0] random_op();
		int         pick;
		logic [2:0] r;
		pick = $urandom_range(0, 99);
		r = random_reg();
		if (pick < 10) return {X_MISC, r, Z_INC};
		if (pick < 20) return {X_MISC, r, Z_DEC};
		if (pick < 35) return {X_MISC, r, Z_LDI};
		if (pick < 80) return {X_ALU, 3'($urandom_range(0, 7)), r};
		if (pick < 95) return {X_JP, 3'($urandom_range(0, 7)), Z_JPCC};
		return OP_JP_NN;
	endfunction

	function automatic bit in_subset(input logic [7:0] op);
		case (op[7:6])
			X_MISC: return op == OP_NOP || (op[5:3] != REG_HL &&
				(op[2:0] == Z_INC || op[2:0] == Z_DEC || op[2:0] == Z_LDI));
			X_ALU:  return op[2:0] != REG_HL;
			X_JP:   return op[2:0] == Z_JPCC || op == OP_JP_NN;
			default: return 1'b0;
		endcase
	endfunction

	task automatic test_directed();
		send_instr({X_MISC, REG_A, Z_LDI}, 8'h7F, 8'h00);
		send_instr({X_MISC, REG_A, Z_INC}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_A, Z_DEC}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_B, Z_LDI}, 8'hFF, 8'hFF);
		send_instr({X_ALU, ALU_ADD, REG_B}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_ADC, REG_A}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_C, Z_LDI}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_SBC, REG_C}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_SUB, REG_B}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_AND, REG_B}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_XOR, REG_A}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_H, Z_LDI}, 8'h80, 8'h00);
		send_instr({X_ALU, ALU_OR, REG_H}, 8'h00, 8'h00);
		send_instr({X_ALU, ALU_CP, REG_B}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_E, Z_DEC}, 8'h00, 8'h00);
		send_instr({X_MISC, REG_L, Z_INC}, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++)
			send_instr({X_JP, 3'(i), Z_JPCC}, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		// jump to the top of memory, then step across the wrap
		send_instr(OP_JP_NN, 8'hFF, 8'hFF);
		send_instr({X_MISC, REG_D, Z_LDI}, 8'h55, 8'hAA);
		wait_for_results();
	endtask

	task automatic test_random(input int idle_pct, input int stall);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (N_RANDOM)
			send_instr(random_op(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		wait_for_results();
	endtask

	// the core halts for good, so this runs last: NOP or an opcode outside the subset
	task automatic test_halt();
		logic [7:0] op;
		send_idle_pct = 20;
		stall_pct = 20;
		if ($urandom_range(0, 1) == 0) begin
			op = OP_NOP;
		end else begin
			do op = 8'($urandom_range(0, 255)); while (in_subset(op));
		end
		send_instr(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		repeat (N_HALTED)
			send_instr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(0, 0);
		test_random(51, 0);
		test_random(0, 51);
		test_random(20, 20);
		test_halt();
		repeat (10) @(posedge clk);
		if (predicted_views.size() != 0) begin
			mismatches += predicted_views.size();
			$display("%0d results never arrived", predicted_views.size());
		end
		$display("ran %0d instructions (%0d jumps) through all idle/stall mixes, ending halted",
			n_accepted, n_jumps);
		$display("compared %0d results field by field, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("z80_subset_execute_core verification clean");
		end else begin
			$display("z80_subset_execute_core verification failed");
		end
		$finish;
	end

endmodule
